### hw/rtl/bf_pkg.sv
`default_nettype none

package bf_pkg;

  // Fixed field and internal widths
  localparam int PIXEL_BITS = 16;
  localparam int K_W        = 4;
  localparam int IW_W       = 12;
  localparam int IH_W       = 13;
  localparam int CH_W       = 2;
  localparam int MODE_W     = 2;
  localparam int FMT_W      = 2;
  localparam int DEC_W      = PIXEL_BITS + 1;
  localparam int CS_W       = 21;
  localparam int SUM_W      = 25;
  localparam int ROW_W      = 14;
  localparam int POS_W      = 16;
  localparam int TAB_N      = 16;
  localparam int MOD_STEPS  = IH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top level parameters
  localparam int DEF_MAX_KERNEL   = 15;
  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_MAX_CHANNELS = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 3'd6;

  // Border modes
  localparam logic [MODE_W-1:0] BM_CONST = 2'd0;
  localparam logic [MODE_W-1:0] BM_REPL  = 2'd1;
  localparam logic [MODE_W-1:0] BM_REFL  = 2'd2;

  // Pixel formats
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_U16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd2;

  // Command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [PIXEL_BITS-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] mean_value;
    logic                  frame_last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_item;
    logic wr_pixel;
    logic restart;
    logic fold_v;
    logic fold_h;
    logic fold_step;
    logic mod_start;
    logic mod_step;
    logic tab_wr;
    logic j_clr;
    logic j_inc;
    logic acc_clr;
    logic b_rd;
    logic b_acc;
    logic cs_wr;
    logic bi_clr;
    logic bi_inc;
    logic m_const;
    logic m_rd;
    logic m_acc;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic yo_ge_h;
    logic out_rdy;
    logic col_zero;
    logic fold_done;
    logic fold_const;
    logic mod_done;
    logic j_last;
    logic bi_last;
    logic div_done;
    logic out_free;
  } stat_t;

  // Raw sample bits to a signed value
  function automatic logic signed [DEC_W-1:0] decode_px(input logic [PIXEL_BITS-1:0] raw,
                                                        input logic [FMT_W-1:0] fmt);
    logic [DEC_W-1:0] v;
    unique case (fmt)
      FMT_U8:  v = {{(DEC_W-8){1'b0}}, raw[7:0]};
      FMT_S16: v = {raw[PIXEL_BITS-1], raw};
      default: v = {1'b0, raw};
    endcase
    return signed'(v);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bf_ram.sv
`default_nettype none

module bf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/bf_ctrl.sv
`default_nettype none

module bf_ctrl
  import bf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output cmd_t       cmd_o,
  input  wire stat_t stat_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WR     = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_VF_LD  = 4'd3;
  localparam logic [3:0] S_VF     = 4'd4;
  localparam logic [3:0] S_VM     = 4'd5;
  localparam logic [3:0] S_B_INIT = 4'd6;
  localparam logic [3:0] S_B_RD   = 4'd7;
  localparam logic [3:0] S_B_ACC  = 4'd8;
  localparam logic [3:0] S_B_WR   = 4'd9;
  localparam logic [3:0] S_HF_LD  = 4'd10;
  localparam logic [3:0] S_HF     = 4'd11;
  localparam logic [3:0] S_M_ACC  = 4'd12;
  localparam logic [3:0] S_DIV0   = 4'd13;
  localparam logic [3:0] S_DIV    = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  logic [3:0] state_q, state_d;
  cmd_t       cmd;

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.ld_item = 1'b1;
          state_d     = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_pixel = 1'b1;
        state_d      = S_CHK;
      end
      S_CHK: begin
        cmd.j_clr   = 1'b1;
        cmd.acc_clr = 1'b1;
        if (stat_i.yo_ge_h) begin
          cmd.restart = 1'b1;
          state_d     = S_IDLE;
        end else if (!stat_i.out_rdy) begin
          state_d = S_IDLE;
        end else if (stat_i.col_zero) begin
          state_d = S_VF_LD;
        end else begin
          state_d = S_HF_LD;
        end
      end
      // slot table for the K rows of this output row
      S_VF_LD: begin
        cmd.fold_v = 1'b1;
        state_d    = S_VF;
      end
      S_VF: begin
        if (!stat_i.fold_done) begin
          cmd.fold_step = 1'b1;
        end else if (stat_i.fold_const) begin
          cmd.tab_wr = 1'b1;
          if (stat_i.j_last) begin
            state_d = S_B_INIT;
          end else begin
            cmd.j_inc = 1'b1;
            state_d   = S_VF_LD;
          end
        end else begin
          cmd.mod_start = 1'b1;
          state_d       = S_VM;
        end
      end
      S_VM: begin
        if (!stat_i.mod_done) begin
          cmd.mod_step = 1'b1;
        end else begin
          cmd.tab_wr = 1'b1;
          if (stat_i.j_last) begin
            state_d = S_B_INIT;
          end else begin
            cmd.j_inc = 1'b1;
            state_d   = S_VF_LD;
          end
        end
      end
      // vertical sums across the row
      S_B_INIT: begin
        cmd.bi_clr  = 1'b1;
        cmd.j_clr   = 1'b1;
        cmd.acc_clr = 1'b1;
        state_d     = S_B_RD;
      end
      S_B_RD: begin
        cmd.b_rd = 1'b1;
        state_d  = S_B_ACC;
      end
      S_B_ACC: begin
        cmd.b_acc = 1'b1;
        if (stat_i.j_last) begin
          state_d = S_B_WR;
        end else begin
          cmd.j_inc = 1'b1;
          state_d   = S_B_RD;
        end
      end
      S_B_WR: begin
        cmd.cs_wr   = 1'b1;
        cmd.j_clr   = 1'b1;
        cmd.acc_clr = 1'b1;
        if (stat_i.bi_last) begin
          state_d = S_HF_LD;
        end else begin
          cmd.bi_inc = 1'b1;
          state_d    = S_B_RD;
        end
      end
      // horizontal sum of K column sums
      S_HF_LD: begin
        cmd.fold_h = 1'b1;
        state_d    = S_HF;
      end
      S_HF: begin
        if (!stat_i.fold_done) begin
          cmd.fold_step = 1'b1;
        end else if (stat_i.fold_const) begin
          cmd.m_const = 1'b1;
          if (stat_i.j_last) begin
            state_d = S_DIV0;
          end else begin
            cmd.j_inc = 1'b1;
            state_d   = S_HF_LD;
          end
        end else begin
          cmd.m_rd = 1'b1;
          state_d  = S_M_ACC;
        end
      end
      S_M_ACC: begin
        cmd.m_acc = 1'b1;
        if (stat_i.j_last) begin
          state_d = S_DIV0;
        end else begin
          cmd.j_inc = 1'b1;
          state_d   = S_HF_LD;
        end
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bf_dpath.sv
`default_nettype none

module bf_dpath
  import bf_pkg::*;
#(
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire in_item_t              in_data_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire cmd_t                  cmd_i,
  output stat_t                      stat_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o
);

  localparam int ROW_SPAN = MAX_WIDTH * MAX_CHANNELS;
  localparam int LS_DEPTH = MAX_KERNEL * ROW_SPAN;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int CS_AW    = $clog2(ROW_SPAN);
  localparam int WC_W     = $clog2(ROW_SPAN + 1);
  localparam int K_CAP    = (MAX_KERNEL - 1) | 1;
  localparam int DCNT_W   = $clog2(SUM_W + 1);

  // Configuration registers
  logic [K_W-1:0]        cfg_k_q;
  logic [IW_W-1:0]       cfg_w_q;
  logic [IH_W-1:0]       cfg_h_q;
  logic [CH_W-1:0]       cfg_ch_q;
  logic [MODE_W-1:0]     cfg_mode_q;
  logic [PIXEL_BITS-1:0] cfg_const_q;
  logic [FMT_W-1:0]      cfg_fmt_q;
  logic                  cfg_hit;

  always_comb begin
    unique case (cfg_index_i)
      CFG_KERNEL, CFG_WIDTH, CFG_HEIGHT, CFG_CHANNELS,
      CFG_BORDER, CFG_CONST, CFG_FORMAT: cfg_hit = cfg_valid_i;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_k_q     <= K_W'(3);
      cfg_w_q     <= IW_W'(640);
      cfg_h_q     <= IH_W'(480);
      cfg_ch_q    <= CH_W'(1);
      cfg_mode_q  <= BM_CONST;
      cfg_const_q <= '0;
      cfg_fmt_q   <= FMT_U8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KERNEL:   cfg_k_q     <= cfg_data_i[K_W-1:0];
        CFG_WIDTH:    cfg_w_q     <= cfg_data_i[IW_W-1:0];
        CFG_HEIGHT:   cfg_h_q     <= cfg_data_i[IH_W-1:0];
        CFG_CHANNELS: cfg_ch_q    <= cfg_data_i[CH_W-1:0];
        CFG_BORDER:   cfg_mode_q  <= cfg_data_i[MODE_W-1:0];
        CFG_CONST:    cfg_const_q <= cfg_data_i;
        CFG_FORMAT:   cfg_fmt_q   <= cfg_data_i[FMT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Effective geometry
  logic [K_W-1:0]          k_odd, k_g;
  logic [K_W-2:0]          half;
  logic [IW_W-1:0]         w_g;
  logic [IH_W-1:0]         h_g;
  logic [CH_W-1:0]         ch_g;
  logic [WC_W-1:0]         wc;
  logic                    mode_const;
  logic signed [DEC_W-1:0] cval;
  logic [7:0]              kk;

  always_comb begin
    k_odd = cfg_k_q | K_W'(1);
    k_g   = (int'(k_odd) > K_CAP) ? K_W'(K_CAP) : k_odd;
    w_g   = (cfg_w_q == '0) ? IW_W'(1) : cfg_w_q;
    if (int'(w_g) > MAX_WIDTH) begin
      w_g = IW_W'(MAX_WIDTH);
    end
    h_g  = (cfg_h_q == '0) ? IH_W'(1) : cfg_h_q;
    ch_g = (cfg_ch_q == '0) ? CH_W'(1) : cfg_ch_q;
    if (int'(ch_g) > MAX_CHANNELS) begin
      ch_g = CH_W'(MAX_CHANNELS);
    end
  end

  assign half       = k_g[K_W-1:1];
  assign wc         = WC_W'(w_g * ch_g);
  assign mode_const = (cfg_mode_q != BM_REPL) && (cfg_mode_q != BM_REFL);
  assign cval       = decode_px(cfg_const_q, cfg_fmt_q);
  assign kk         = 8'(k_g * k_g);

  // Item latch
  in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      item_q <= in_data_i;
    end
  end

  // Frame position counters
  logic [WC_W-1:0]  in_col_q, ocol_q, bi_q;
  logic [ROW_W-1:0] in_row_q, yo_q;
  logic [K_W-1:0]   in_slot_q, j_q;
  logic [IW_W-1:0]  ox_q;
  logic [CH_W-1:0]  oc_q;
  logic             px_write, row_end, frame_last, restart;

  assign px_write   = cmd_i.wr_pixel && (item_q.command == CMD_PIXEL) &&
                      (in_row_q < ROW_W'(h_g)) && (in_col_q < wc);
  assign row_end    = (in_col_q + WC_W'(1)) >= wc;
  assign frame_last = (yo_q == ROW_W'(h_g) - ROW_W'(1)) && (ocol_q == wc - WC_W'(1));
  assign restart    = cfg_hit || cmd_i.restart || (cmd_i.out_load && frame_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_slot_q <= '0;
      yo_q      <= '0;
      ocol_q    <= '0;
      ox_q      <= '0;
      oc_q      <= '0;
    end else if (restart) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_slot_q <= '0;
      yo_q      <= '0;
      ocol_q    <= '0;
      ox_q      <= '0;
      oc_q      <= '0;
    end else begin
      if (px_write) begin
        if (row_end) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + ROW_W'(1);
          in_slot_q <= (in_slot_q + K_W'(1) == k_g) ? '0 : in_slot_q + K_W'(1);
        end else begin
          in_col_q <= in_col_q + WC_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        if (ocol_q + WC_W'(1) == wc) begin
          ocol_q <= '0;
          yo_q   <= yo_q + ROW_W'(1);
          ox_q   <= '0;
          oc_q   <= '0;
        end else begin
          ocol_q <= ocol_q + WC_W'(1);
          if (oc_q + CH_W'(1) == ch_g) begin
            oc_q <= '0;
            ox_q <= ox_q + IW_W'(1);
          end else begin
            oc_q <= oc_q + CH_W'(1);
          end
        end
      end
    end
  end

  // Output row readiness
  logic [ROW_W-1:0] need, h_m1;
  always_comb begin
    h_m1 = ROW_W'(h_g) - ROW_W'(1);
    need = yo_q + ROW_W'(half);
    if (need > h_m1) begin
      need = h_m1;
    end
  end

  // Border fold unit, one fold per cycle
  logic signed [POS_W-1:0] fold_p_q, fold_nx;
  logic [IH_W-1:0]         fold_len_q;
  logic                    fold_in, fold_done, fold_const;

  assign fold_in    = !fold_p_q[POS_W-1] &&
                      (fold_p_q[POS_W-2:0] < (POS_W-1)'(fold_len_q));
  assign fold_done  = fold_in || mode_const;
  assign fold_const = !fold_in && mode_const;

  always_comb begin
    if (cfg_mode_q == BM_REPL) begin
      fold_nx = fold_p_q[POS_W-1] ? '0 : signed'(POS_W'(fold_len_q) - POS_W'(1));
    end else if (fold_len_q == IH_W'(1)) begin
      fold_nx = '0;
    end else if (fold_p_q[POS_W-1]) begin
      fold_nx = -fold_p_q;
    end else begin
      fold_nx = signed'(POS_W'({fold_len_q, 1'b0}) - POS_W'(2)) - fold_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fold_v) begin
      fold_p_q   <= signed'(POS_W'(yo_q)) - signed'(POS_W'(half)) + signed'(POS_W'(j_q));
      fold_len_q <= h_g;
    end else if (cmd_i.fold_h) begin
      fold_p_q   <= signed'(POS_W'(ox_q)) - signed'(POS_W'(half)) + signed'(POS_W'(j_q));
      fold_len_q <= IH_W'(w_g);
    end else if (cmd_i.fold_step) begin
      fold_p_q <= fold_nx;
    end
  end

  // Row slot: remainder by K, one bit per cycle
  logic [IH_W-1:0]      mod_rem_q;
  logic [K_W-1:0]       mod_cnt_q;
  logic [IH_W+K_W-1:0]  mod_div;

  assign mod_div = (IH_W+K_W)'(k_g) << (mod_cnt_q - K_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_cnt_q <= '0;
    end else if (cmd_i.mod_start) begin
      mod_cnt_q <= K_W'(MOD_STEPS);
    end else if (cmd_i.mod_step) begin
      mod_cnt_q <= mod_cnt_q - K_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      mod_rem_q <= fold_p_q[IH_W-1:0];
    end else if (cmd_i.mod_step && ((IH_W+K_W)'(mod_rem_q) >= mod_div)) begin
      mod_rem_q <= mod_rem_q - mod_div[IH_W-1:0];
    end
  end

  // Tap counter and slot table
  logic [K_W-1:0] tab_slot_q [TAB_N];
  logic           tab_const_q [TAB_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q  <= '0;
      bi_q <= '0;
    end else begin
      if (cmd_i.j_clr) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + K_W'(1);
      end
      if (cmd_i.bi_clr) begin
        bi_q <= '0;
      end else if (cmd_i.bi_inc) begin
        bi_q <= bi_q + WC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_wr) begin
      tab_slot_q[j_q]  <= mod_rem_q[K_W-1:0];
      tab_const_q[j_q] <= fold_const;
    end
  end

  // Line store
  logic [LS_AW-1:0]      ls_waddr, ls_raddr;
  logic [PIXEL_BITS-1:0] ls_wdata, ls_rdata;

  assign ls_waddr = LS_AW'(in_slot_q * ROW_SPAN) + LS_AW'(in_col_q);
  assign ls_raddr = LS_AW'(tab_slot_q[j_q] * ROW_SPAN) + LS_AW'(bi_q);
  assign ls_wdata = (cfg_fmt_q == FMT_U8) ?
                    {{(PIXEL_BITS-8){1'b0}}, item_q.pixel_value[7:0]} : item_q.pixel_value;

  bf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (LS_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (px_write),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .re_i    (cmd_i.b_rd),
    .raddr_i (ls_raddr),
    .rdata_o (ls_rdata)
  );

  // Column sums
  logic signed [SUM_W-1:0] acc_q;
  logic [CS_AW-1:0]        cs_raddr;
  logic [CS_W-1:0]         cs_rdata;

  assign cs_raddr = CS_AW'(fold_p_q[IW_W-1:0] * ch_g) + CS_AW'(oc_q);

  bf_ram #(
    .WIDTH (CS_W),
    .DEPTH (ROW_SPAN)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cs_wr),
    .waddr_i (bi_q[CS_AW-1:0]),
    .wdata_i (acc_q[CS_W-1:0]),
    .re_i    (cmd_i.m_rd),
    .raddr_i (cs_raddr),
    .rdata_o (cs_rdata)
  );

  // Window accumulator
  logic signed [DEC_W-1:0]   tap_px;
  logic signed [DEC_W+K_W:0] kc;

  assign tap_px = tab_const_q[j_q] ? cval : decode_px(ls_rdata, cfg_fmt_q);
  assign kc     = signed'({1'b0, k_g}) * cval;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.b_acc) begin
      acc_q <= acc_q + SUM_W'(tap_px);
    end else if (cmd_i.m_const) begin
      acc_q <= acc_q + SUM_W'(kc);
    end else if (cmd_i.m_acc) begin
      acc_q <= acc_q + SUM_W'(signed'(cs_rdata));
    end
  end

  // Divide by K*K, restoring, one quotient bit per cycle
  logic [SUM_W-1:0]  dq_q;
  logic [7:0]        drem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              dneg_q;
  logic [8:0]        dtrial;
  logic [SUM_W-1:0]  mean_full;
  logic [PIXEL_BITS-1:0] mean_px;

  assign dtrial = {drem_q, dq_q[SUM_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DCNT_W'(SUM_W);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q   <= acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
      dneg_q <= acc_q[SUM_W-1];
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dtrial >= {1'b0, kk}) begin
        drem_q <= 8'(dtrial - {1'b0, kk});
        dq_q   <= {dq_q[SUM_W-2:0], 1'b1};
      end else begin
        drem_q <= dtrial[7:0];
        dq_q   <= {dq_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign mean_full = dneg_q ? (~dq_q + SUM_W'(1)) : dq_q;
  assign mean_px   = (cfg_fmt_q == FMT_U8) ?
                     {{(PIXEL_BITS-8){1'b0}}, mean_full[7:0]} : mean_full[PIXEL_BITS-1:0];

  // Output register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.mean_value <= mean_px;
      out_q.frame_last <= frame_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller
  always_comb begin
    stat_o.yo_ge_h    = yo_q >= ROW_W'(h_g);
    stat_o.out_rdy    = in_row_q >= need + ROW_W'(1);
    stat_o.col_zero   = (ocol_q == '0);
    stat_o.fold_done  = fold_done;
    stat_o.fold_const = fold_const;
    stat_o.mod_done   = (mod_cnt_q == '0);
    stat_o.j_last     = (j_q == k_g - K_W'(1));
    stat_o.bi_last    = (bi_q == wc - WC_W'(1));
    stat_o.div_done   = (dcnt_q == '0);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

### hw/rtl/box_filter_kxk.sv
// KxK box filter: takes one channel sample per beat in raster order (channels
// interleaved) and gives the KxK window mean of each sample, truncated toward
// zero, with constant, replicate or reflect-101 borders. Results lag the input
// by about K/2 rows; flush beats after the frame drain the remaining rows.
// Items are worked one at a time by a sequencer. A sample that yields no
// result is only written to the line store. For a result in mid-row, each of
// the K taps is folded into the image with f border folds (0 inside the image)
// and adds a column sum read from the column-sum RAM, or K times the constant on
// the constant border. The first result of each output row also rebuilds the
// vertical column sums: a row slot per tap by border fold and remainder by K,
// then the line-store sums for every column, one line-store read per tap.
// The divide by K*K is a restoring divider, one quotient bit per cycle over 25
// bits, and the result register is loaded once the output side is free.
// Configuration writes restart the frame and are taken in any cycle.
`default_nettype none

module box_filter_kxk
  import bf_pkg::*;
#(
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  bf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  bf_dpath #(
    .MAX_KERNEL   (MAX_KERNEL),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
